// ===== rtl/okvt_pkg.sv =====
// Shared types and codes for the ordered key/value table.
// Holds the request and result item structs, action codes and the
// command/status structs between the controller and the datapath.
package okvt_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Action codes carried in the request item.
  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_UPDATE   = 3'd1;
  localparam logic [2:0] ACT_UPSERT   = 3'd2;
  localparam logic [2:0] ACT_ERASE    = 3'd3;
  localparam logic [2:0] ACT_LOOKUP   = 3'd4;
  localparam logic [2:0] ACT_READ_IDX = 3'd5;

  // How the datapath forms the pending result.
  localparam logic [1:0] RES_FAIL   = 2'd0;
  localparam logic [1:0] RES_OK     = 2'd1;
  localparam logic [1:0] RES_LOOKUP = 2'd2;
  localparam logic [1:0] RES_INDEX  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  position;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [8:0]  entry_count;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       scan;
    logic       shift;
    logic       idx_read;
    logic       wr_update;
    logic       wr_append;
    logic       dec_count;
    logic       res_set;
    logic [1:0] res_kind;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       pos_ok;
    logic       match;
    logic       scan_end;
    logic       shift_done;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/okvt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the table entry storage.
module okvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/okvt_datapath.sv =====
// Datapath of the ordered key/value table: request register, entry RAM,
// scan/shift pipeline, entry count and the result output register.
// Depends on okvt_pkg and okvt_ram.
module okvt_datapath #(
  parameter int CAPACITY   = okvt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = okvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = okvt_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  okvt_pkg::request_t request,
  input  okvt_pkg::cmd_t     cmd,
  output okvt_pkg::status_t  status,
  input  logic               result_stall,
  output logic               result_valid,
  output okvt_pkg::result_t  result
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam int DW   = KEY_BITS + VALUE_BITS;

  logic [2:0]            req_action;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [7:0]            req_pos;

  logic [CW-1:0] count;
  logic [CW-1:0] addr;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic                  res_ok;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;

  logic                  issue;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  pipe_empty;

  assign rd_key   = rd_data[VALUE_BITS +: KEY_BITS];
  assign rd_value = rd_data[VALUE_BITS-1:0];

  // Reads run one entry per cycle; the compare works on the registered read data in the cycle after the read is issued.
  assign issue   = (cmd.scan || cmd.shift) && (addr < count);
  assign rd_en   = issue || cmd.idx_read;
  assign rd_addr = cmd.idx_read ? AW'(req_pos) : addr[AW-1:0];

  assign wr_en   = cmd.wr_update || cmd.wr_append || (cmd.shift && pend);
  assign wr_data = cmd.shift ? rd_data : {req_key, req_value};

  always_comb begin
    if (cmd.wr_update) begin
      wr_addr = pend_addr;
    end else if (cmd.wr_append) begin
      wr_addr = count[AW-1:0];
    end else begin
      wr_addr = pend_addr - AW'(1);
    end
  end

  okvt_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_action <= request.action;
      req_key    <= KEY_BITS'(request.key);
      req_value  <= VALUE_BITS'(request.value);
      req_pos    <= request.position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      pend <= 1'b0;
    end else if (cmd.load_req) begin
      addr <= '0;
      pend <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        addr <= addr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_addr <= addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_append) begin
      count <= count + CW'(1);
    end else if (cmd.dec_count) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res_kind)
        okvt_pkg::RES_OK: begin
          res_ok    <= 1'b1;
          res_key   <= '0;
          res_value <= '0;
        end
        okvt_pkg::RES_LOOKUP: begin
          res_ok    <= 1'b1;
          res_key   <= '0;
          res_value <= rd_value;
        end
        okvt_pkg::RES_INDEX: begin
          res_ok    <= 1'b1;
          res_key   <= rd_key;
          res_value <= rd_value;
        end
        default: begin
          res_ok    <= 1'b0;
          res_key   <= '0;
          res_value <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.ok          <= res_ok;
      result.key_out     <= 32'(res_key);
      result.value_out   <= 32'(res_value);
      result.entry_count <= 9'(count);
    end
  end

  assign pipe_empty = !pend && (addr >= count);

  assign status.action     = req_action;
  assign status.full       = (count == CW'(CAPACITY));
  assign status.pos_ok     = (CMPW'(req_pos) < CMPW'(count));
  assign status.match      = pend && (rd_key == req_key);
  assign status.scan_end   = (pend && ((CW'(pend_addr) + CW'(1)) >= count)) || pipe_empty;
  assign status.shift_done = pipe_empty;
  assign status.out_free   = !result_valid || !result_stall;

endmodule

// ===== rtl/okvt_ctrl.sv =====
// Controller state machine of the ordered key/value table.
// Sequences dispatch, key scan, erase shift and result delivery. Uses okvt_pkg.
module okvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              busy,
  input  okvt_pkg::status_t status,
  output okvt_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_SHIFT    = 3'd3;
  localparam logic [2:0] ST_IDXWAIT  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (request_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.action) inside
          okvt_pkg::ACT_INSERT: begin
            if (status.full) begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = okvt_pkg::RES_FAIL;
              state_next   = ST_DONE;
            end else begin
              state_next = ST_SCAN;
            end
          end
          okvt_pkg::ACT_UPDATE, okvt_pkg::ACT_UPSERT, okvt_pkg::ACT_ERASE,
          okvt_pkg::ACT_LOOKUP: begin
            state_next = ST_SCAN;
          end
          okvt_pkg::ACT_READ_IDX: begin
            if (status.pos_ok) begin
              cmd.idx_read = 1'b1;
              state_next   = ST_IDXWAIT;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = okvt_pkg::RES_FAIL;
              state_next   = ST_DONE;
            end
          end
          default: begin
            cmd.res_set  = 1'b1;
            cmd.res_kind = okvt_pkg::RES_FAIL;
            state_next   = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) begin
          unique case (status.action) inside
            okvt_pkg::ACT_UPDATE, okvt_pkg::ACT_UPSERT: begin
              cmd.wr_update = 1'b1;
              cmd.res_set   = 1'b1;
              cmd.res_kind  = okvt_pkg::RES_OK;
              state_next    = ST_DONE;
            end
            okvt_pkg::ACT_ERASE: begin
              state_next = ST_SHIFT;
            end
            okvt_pkg::ACT_LOOKUP: begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = okvt_pkg::RES_LOOKUP;
              state_next   = ST_DONE;
            end
            default: begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = okvt_pkg::RES_FAIL;
              state_next   = ST_DONE;
            end
          endcase
        end else if (status.scan_end) begin
          cmd.res_set = 1'b1;
          state_next  = ST_DONE;
          if ((status.action == okvt_pkg::ACT_INSERT ||
               status.action == okvt_pkg::ACT_UPSERT) && !status.full) begin
            cmd.wr_append = 1'b1;
            cmd.res_kind  = okvt_pkg::RES_OK;
          end else begin
            cmd.res_kind = okvt_pkg::RES_FAIL;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          cmd.dec_count = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_kind  = okvt_pkg::RES_OK;
          state_next    = ST_DONE;
        end
      end
      ST_IDXWAIT: begin
        cmd.res_set  = 1'b1;
        cmd.res_kind = okvt_pkg::RES_INDEX;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ordered_key_value_table_unit.sv =====
// Ordered key/value table of up to CAPACITY unique pairs in insertion order.
// Request items enter on request/request_valid/request_stall; each request gives
// exactly one result item on result/result_valid/result_stall.
// An item is accepted on a rising edge with valid high and stall low.
// Actions: insert, update, insert-or-update, erase (later pairs move down one
// place), lookup by key and read by position; unused action codes fail.
// Every result carries ok, key_out, value_out and the entry count after it.
// One item is worked on at a time. The key scan reads the entry RAM
// one entry per cycle through its registered read port, and erase
// continues at one moved entry per cycle. Read by position and insert
// into a full table skip the scan. The next request is taken in the
// cycle after a result reaches the output register.
// The result sits in an output register, so a finished result waits there
// while the next request is accepted; if the receiver stalls, the following
// result is held inside until the output register is free.
// Reset (rst, synchronous) empties the table and drops any result in flight;
// entry storage is not cleared, since only positions below the count are read.
module ordered_key_value_table_unit #(
  parameter int CAPACITY   = okvt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = okvt_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = okvt_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  okvt_pkg::request_t request,
  output logic               result_valid,
  input  logic               result_stall,
  output okvt_pkg::result_t  result
);

  okvt_pkg::cmd_t    cmd;
  okvt_pkg::status_t status;
  logic              busy;

  // New requests are taken only while the controller is idle.
  assign request_stall = busy;

  okvt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .busy          (busy),
    .status        (status),
    .cmd           (cmd)
  );

  okvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== test/tb_ordered_key_value_table_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ordered_key_value_table_unit.
// Depends on okvt_pkg for the request and result item types and the action codes.
module tb_ordered_key_value_table_unit;

  // Codes 6 and 7 carry no action; the block must answer them with a plain failure.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int CAP          = okvt_pkg::DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_EVERY  = 150;
  // A key action walks the whole table at worst, so this covers one item in flight.
  localparam int TAIL_CYCLES  = CAP + 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PRINT_LIMIT  = 40;

  // Stimulus steers the table through filling, sitting full, draining and mixed traffic.
  typedef enum {MODE_GROW, MODE_FULL, MODE_SHRINK, MODE_MIX} load_mode_t;

  // One queued request with the result it must produce. When drain_first is set,
  // the driver holds it back until every earlier result has come out.
  typedef struct {
    okvt_pkg::request_t req;
    okvt_pkg::result_t  want;
    bit                 drain_first;
  } table_op_t;

  logic               clk;
  logic               rst           = 1'b1;
  logic               request_valid = 1'b0;
  logic               request_stall;
  okvt_pkg::request_t request       = '0;
  logic               result_valid;
  logic               result_stall  = 1'b0;
  okvt_pkg::result_t  result;

  // Expected result that travels next to the request on the wire.
  okvt_pkg::result_t request_want = '0;

  table_op_t         pending_items[$];
  okvt_pkg::result_t expected_results[$];

  // Predictor copy of the table contents.
  logic [31:0] map_key[CAP];
  logic [31:0] map_val[CAP];
  int          map_cnt = 0;

  int n_errors      = 0;
  int n_sent        = 0;
  int n_results     = 0;
  int n_ok          = 0;
  int peak_cnt      = 0;
  int full_refusals = 0;

  ordered_key_value_table_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. The table keeps its pairs packed in insertion order, so a key
  // search is a linear walk over the first map_cnt slots.
  // ---------------------------------------------------------------------------
  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < map_cnt; i++) begin
      if (map_key[i] == k) return i;
    end
    return map_cnt;
  endfunction

  function automatic okvt_pkg::result_t predict_request(okvt_pkg::request_t rq);
    okvt_pkg::result_t r;
    int                slot;
    r    = '0;
    slot = find_slot(rq.key);
    case (rq.action) inside
      okvt_pkg::ACT_INSERT, okvt_pkg::ACT_UPSERT: begin
        // Insert-or-update on a present key behaves as update; a plain insert
        // of a present key is refused. A new key needs a free slot.
        if (slot < map_cnt) begin
          if (rq.action == okvt_pkg::ACT_UPSERT) begin
            map_val[slot] = rq.value;
            r.ok = 1'b1;
          end
        end else if (map_cnt < CAP) begin
          map_key[map_cnt] = rq.key;
          map_val[map_cnt] = rq.value;
          map_cnt++;
          r.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      okvt_pkg::ACT_UPDATE: begin
        if (slot < map_cnt) begin
          map_val[slot] = rq.value;
          r.ok = 1'b1;
        end
      end
      okvt_pkg::ACT_ERASE: begin
        // Later pairs move down one place to close the gap.
        if (slot < map_cnt) begin
          for (int i = slot; i + 1 < map_cnt; i++) begin
            map_key[i] = map_key[i + 1];
            map_val[i] = map_val[i + 1];
          end
          map_cnt--;
          r.ok = 1'b1;
        end
      end
      okvt_pkg::ACT_LOOKUP: begin
        if (slot < map_cnt) begin
          r.value_out = map_val[slot];
          r.ok = 1'b1;
        end
      end
      okvt_pkg::ACT_READ_IDX: begin
        if (int'(rq.position) < map_cnt) begin
          r.key_out   = map_key[rq.position];
          r.value_out = map_val[rq.position];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 9'(map_cnt);
    if (map_cnt > peak_cnt) peak_cnt = map_cnt;
    return r;
  endfunction

  // Items are predicted as they are queued; the driver sends them in the same
  // order, so the predictor state always matches what the block has seen.
  task automatic queue_request(logic [2:0] act, logic [31:0] k, logic [31:0] v,
                               logic [7:0] pos, bit drain);
    table_op_t op;
    op.req.action   = act;
    op.req.key      = k;
    op.req.value    = v;
    op.req.position = pos;
    op.want         = predict_request(op.req);
    op.drain_first  = drain;
    pending_items.push_back(op);
  endtask

  function automatic logic [2:0] pick_action(load_mode_t m);
    logic [2:0] codes[6];
    int         w[6];
    int         roll;
    codes = '{okvt_pkg::ACT_INSERT, okvt_pkg::ACT_UPSERT, okvt_pkg::ACT_UPDATE,
              okvt_pkg::ACT_ERASE, okvt_pkg::ACT_LOOKUP, okvt_pkg::ACT_READ_IDX};
    case (m) inside
      MODE_GROW, MODE_FULL: w = '{55, 20, 5, 5, 7, 8};
      MODE_SHRINK:          w = '{5, 5, 5, 70, 7, 8};
      default:              w = '{17, 17, 16, 16, 17, 17};
    endcase
    if ($urandom_range(0, 99) < 3) return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    roll = $urandom_range(0, 99);
    for (int a = 0; a < 6; a++) begin
      if (roll < w[a]) return codes[a];
      roll -= w[a];
    end
    return okvt_pkg::ACT_READ_IDX;
  endfunction

  // How often a key is taken from the stored pairs rather than made up.
  function automatic int hit_percent(logic [2:0] act);
    case (act) inside
      okvt_pkg::ACT_INSERT: return 15;
      okvt_pkg::ACT_UPSERT: return 45;
      okvt_pkg::ACT_UPDATE, okvt_pkg::ACT_ERASE, okvt_pkg::ACT_LOOKUP: return 85;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] edge_or_random();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 32'h0000_0000;
    if (roll < 10) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= PRINT_LIMIT)
      $display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
               $time, n_results, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver. Items go out in bursts of random length separated by random gaps,
  // some of them zero so that back-to-back traffic also occurs. The payload
  // stays put while the block stalls, and valid stays high across an accept
  // when the next item follows at once.
  // ---------------------------------------------------------------------------
  bit        drv_sending;
  int        burst_left = 0;
  int        gap_left   = 0;
  table_op_t drv_next;

  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
      request       <= '0;
      request_want  <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      drv_sending = request_valid;
      if (request_valid && !request_stall) begin
        drv_sending = 1'b0;
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          case ($urandom_range(0, 9)) inside
            [0:5]:   gap_left = 0;
            [6:8]:   gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(10, 40);
          endcase
        end
      end
      if (!drv_sending) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || n_results == n_sent)) begin
          drv_next = pending_items.pop_front();
          request      <= drv_next.req;
          request_want <= drv_next.want;
          drv_sending = 1'b1;
        end
      end
      request_valid <= drv_sending;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall. It rotates through three styles: never stalling,
  // stalling on about a third of the cycles, and rare long stalls.
  // ---------------------------------------------------------------------------
  int stall_tick = 0;
  int stall_run  = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_tick = 0;
      stall_run  = 0;
    end else begin
      stall_tick++;
      if (stall_run > 0) begin
        stall_run--;
        result_stall <= 1'b1;
      end else begin
        case ((stall_tick / 300) % 3)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if ($urandom_range(0, 24) == 0) stall_run = $urandom_range(4, 30);
            result_stall <= (stall_run > 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. A result is checked against the oldest expectation first; the
  // expectation of a request accepted on the same edge is queued after that,
  // so both sides are handled in one fixed order.
  // ---------------------------------------------------------------------------
  okvt_pkg::result_t head_want;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        n_results++;
        if (result.ok === 1'b1) n_ok++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", result.value_out, '0);
        end else begin
          head_want = expected_results.pop_front();
          if (result.ok !== head_want.ok)
            report_mismatch("ok", 32'(result.ok), 32'(head_want.ok));
          if (result.key_out !== head_want.key_out)
            report_mismatch("key_out", result.key_out, head_want.key_out);
          if (result.value_out !== head_want.value_out)
            report_mismatch("value_out", result.value_out, head_want.value_out);
          if (result.entry_count !== head_want.entry_count)
            report_mismatch("entry_count", 32'(result.entry_count),
                            32'(head_want.entry_count));
        end
      end
      if (request_valid && !request_stall) expected_results.push_back(request_want);
    end
  end

  // Watchdog: a long stretch with no item moving on either side means the
  // block has hung.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((request_valid && !request_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    load_mode_t  mode;
    int          mode_left;
    logic [2:0]  act;
    logic [31:0] k;
    logic [31:0] v;
    logic [7:0]  pos;

    // Directed part on an empty table first: every miss case, then a few pairs
    // at the key and value extremes.
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd0, 1'b0);
    queue_request(okvt_pkg::ACT_LOOKUP, 32'h0000_0000, $urandom(), 8'($urandom()), 1'b0);
    queue_request(okvt_pkg::ACT_ERASE, 32'hFFFF_FFFF, $urandom(), 8'($urandom()), 1'b0);
    queue_request(okvt_pkg::ACT_UPDATE, 32'h0000_0001, $urandom(), 8'($urandom()), 1'b0);
    queue_request(okvt_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'($urandom()),
                  1'b0);
    queue_request(okvt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 8'($urandom()),
                  1'b0);
    // A duplicate insert is refused and leaves the stored value alone.
    queue_request(okvt_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0001, 8'($urandom()),
                  1'b0);
    // Insert-or-update takes the update path here, then the insert path.
    queue_request(okvt_pkg::ACT_UPSERT, 32'hFFFF_FFFF, 32'h1234_5678, 8'($urandom()),
                  1'b0);
    queue_request(okvt_pkg::ACT_UPSERT, 32'h8000_0001, 32'h5A5A_5A5A, 8'($urandom()),
                  1'b0);
    queue_request(okvt_pkg::ACT_UPDATE, 32'h0000_0000, 32'hA5A5_A5A5, 8'($urandom()),
                  1'b0);
    queue_request(okvt_pkg::ACT_UPDATE, 32'h0000_0007, $urandom(), 8'($urandom()), 1'b0);
    queue_request(okvt_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, $urandom(), 8'($urandom()), 1'b0);
    // Read by position: the last pair, one past the end, and the top position.
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd2, 1'b0);
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd3, 1'b0);
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd255, 1'b0);
    // Erasing the first pair moves the other two down; the sender waits for
    // the block to go quiet before it.
    queue_request(okvt_pkg::ACT_ERASE, 32'h0000_0000, $urandom(), 8'($urandom()), 1'b1);
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd0, 1'b0);
    queue_request(okvt_pkg::ACT_READ_IDX, $urandom(), $urandom(), 8'd1, 1'b0);
    queue_request(ACT_SPARE_LO, $urandom(), $urandom(), 8'($urandom()), 1'b0);
    queue_request(ACT_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b0);
    // Erasing the last pair needs no move at all.
    queue_request(okvt_pkg::ACT_ERASE, 32'h8000_0001, $urandom(), 8'($urandom()), 1'b0);
    queue_request(okvt_pkg::ACT_LOOKUP, 32'h8000_0001, $urandom(), 8'($urandom()), 1'b0);

    // Random part. The table is filled to capacity, pressed with inserts while
    // full, drained back to empty and then given mixed traffic, over and over.
    mode      = MODE_GROW;
    mode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (mode)
        MODE_GROW: begin
          if (map_cnt == CAP) begin
            mode      = MODE_FULL;
            mode_left = 40;
          end
        end
        MODE_FULL: begin
          mode_left--;
          if (mode_left <= 0) mode = MODE_SHRINK;
        end
        MODE_SHRINK: begin
          if (map_cnt == 0) begin
            mode      = MODE_MIX;
            mode_left = 120;
          end
        end
        default: begin
          mode_left--;
          if (mode_left <= 0) mode = MODE_GROW;
        end
      endcase

      act = pick_action(mode);
      if (map_cnt > 0 && $urandom_range(0, 99) < hit_percent(act))
        k = map_key[$urandom_range(0, map_cnt - 1)];
      else
        k = edge_or_random();
      v = edge_or_random();
      if (map_cnt > 0 && $urandom_range(0, 4) != 0)
        pos = 8'($urandom_range(0, map_cnt - 1));
      else
        pos = 8'($urandom_range(0, 255));
      queue_request(act, k, v, pos, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || request_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    // Any stray result the block still has in hand shows up here.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results, %0d of them successful.",
             n_sent, n_results, n_ok);
    $display("Table reached %0d of %0d entries; %0d inserts were refused while full.",
             peak_cnt, CAP, full_refusals);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/okvt_pkg.sv
rtl/okvt_ram.sv
rtl/okvt_datapath.sv
rtl/okvt_ctrl.sv
rtl/ordered_key_value_table_unit.sv
test/tb_ordered_key_value_table_unit.sv
